@@ design/held_note_chord_recognizer_defines.svh @@
// Assertion macros used by the bound checker in hncr_checker.sv.
`ifndef HELD_NOTE_CHORD_RECOGNIZER_DEFINES_SVH
`define HELD_NOTE_CHORD_RECOGNIZER_DEFINES_SVH

// Same-cycle implication.
`define HNCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HNCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/hncr_pkg.sv @@
`default_nettype none

package hncr_pkg;

   localparam int PC_COUNT   = 12;
   localparam int KIND_COUNT = 8;
   localparam int SCORE_W    = 10;

   localparam int W_PRESENT = 40;
   localparam int W_ABSENT  = -46;
   localparam int W_EXTRA   = 13;
   localparam int W_BASS    = 12;

   localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
   localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [1:0] MODE_ALL_OFF  = 2'd2;

   localparam logic [1:0] CSR_FALLBACK_ROOT = 2'd0;
   localparam logic [1:0] CSR_FALLBACK_KIND = 2'd1;

   typedef struct packed {
      logic [1:0] mode;
      logic [6:0] note_number;
   } req_type;

   typedef struct packed {
      logic       chord_found;
      logic [3:0] chord_root;
      logic [2:0] chord_kind;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SCORE,
      S_EMIT
   } state_type;

   // Interval mask of each chord kind, bit i = i semitones above the root.
   function automatic logic [PC_COUNT-1:0] kind_mask(input logic [2:0] kind);
      logic [PC_COUNT-1:0] m;
      case (kind)
         3'd0:    m = 12'b0000_1001_0001;
         3'd1:    m = 12'b0000_1000_1001;
         3'd2:    m = 12'b0100_1001_0001;
         3'd3:    m = 12'b1000_1001_0001;
         3'd4:    m = 12'b0100_1000_1001;
         3'd5:    m = 12'b0000_1000_0101;
         3'd6:    m = 12'b0000_1010_0001;
         3'd7:    m = 12'b0000_1001_0101;
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [3:0] popcount12(input logic [PC_COUNT-1:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < PC_COUNT; i++) begin
         c = c + 4'(v[i]);
      end
      return c;
   endfunction

   // rot has the root's class at bit 0.
   function automatic logic signed [SCORE_W-1:0] template_score(
      input logic [PC_COUNT-1:0] rot,
      input logic [2:0]          kind,
      input logic [PC_COUNT-1:0] pcs,
      input logic                bass
   );
      logic [PC_COUNT-1:0] m;
      logic [3:0]          p;
      logic [3:0]          t;
      logic [3:0]          h;
      int                  s;
      m = kind_mask(kind);
      p = popcount12(m & rot);
      t = popcount12(m);
      h = popcount12(pcs);
      s = (W_PRESENT - W_ABSENT + W_EXTRA) * int'(p) + W_ABSENT * int'(t)
          - W_EXTRA * int'(h) + (bass ? W_BASS : 0);
      return SCORE_W'(s);
   endfunction

endpackage

`default_nettype wire

@@ design/held_note_chord_recognizer.sv @@
// Held-note chord recognizer. Each accepted transaction (note on, note off or
// all notes off) updates a map of held notes, then the block scans the map one
// note per cycle to build the pitch-class set and the bass class, and scores
// the 96 chord templates one per cycle on a single shared scoring unit when
// any note is held. req_stall stays high from acceptance until the result has
// been loaded into the result register. The result waits in an output register,
// and a transaction that finishes while the previous result is still unread
// waits until that result is taken. csr_ready is always high; writes are meant
// for when the block is idle.
`default_nettype none

module held_note_chord_recognizer #(
   parameter int unsigned NOTE_COUNT = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hncr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hncr_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [3:0]       csr_data
);
   import hncr_pkg::*;

   localparam int NIDX_W = $clog2(NOTE_COUNT);
   localparam logic [NIDX_W-1:0] LAST_NOTE = NIDX_W'(NOTE_COUNT - 1);

   state_type state_ff, state_in;

   logic [NOTE_COUNT-1:0] held_ff, held_in;
   logic [3:0]            fb_root_ff, fb_root_in;
   logic [2:0]            fb_kind_ff, fb_kind_in;

   logic [NIDX_W-1:0]   scan_ff, scan_in;
   logic [3:0]          pc_ff, pc_in;
   logic [PC_COUNT-1:0] pcs_ff, pcs_in;
   logic [3:0]          low_ff, low_in;
   logic                found_ff, found_in;

   logic [PC_COUNT-1:0]       rot_ff, rot_in;
   logic [3:0]                root_ff, root_in;
   logic [2:0]                kind_ff, kind_in;
   logic                      first_ff, first_in;
   logic signed [SCORE_W-1:0] best_ff, best_in;
   logic [3:0]                broot_ff, broot_in;
   logic [2:0]                bkind_ff, bkind_in;
   logic signed [SCORE_W-1:0] score;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic req_take;
   logic rsp_load;
   logic note_ok;
   logic scan_last;
   logic score_last;

   assign req_take   = req_valid && !req_stall;
   assign note_ok    = {1'b0, req_data.note_number} < 8'(NOTE_COUNT);
   assign scan_last  = (scan_ff == LAST_NOTE);
   assign score_last = (root_ff == 4'(PC_COUNT - 1)) && (kind_ff == 3'(KIND_COUNT - 1));
   assign score      = template_score(rot_ff, kind_ff, pcs_ff, root_ff == low_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_last) state_in = found_in ? S_SCORE : S_EMIT;
         end
         S_SCORE: begin
            if (score_last) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE:  req_stall = 1'b0;
         S_EMIT:  rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // held map and configuration
   always_comb begin
      held_in    = held_ff;
      fb_root_in = fb_root_ff;
      fb_kind_in = fb_kind_ff;
      if (req_take) begin
         case (req_data.mode)
            MODE_NOTE_ON: begin
               if (note_ok) held_in[req_data.note_number[NIDX_W-1:0]] = 1'b1;
            end
            MODE_NOTE_OFF: begin
               if (note_ok) held_in[req_data.note_number[NIDX_W-1:0]] = 1'b0;
            end
            MODE_ALL_OFF: held_in = '0;
            default: ;
         endcase
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FALLBACK_ROOT: fb_root_in = csr_data;
            CSR_FALLBACK_KIND: fb_kind_in = csr_data[2:0];
            default: ;
         endcase
      end
   end

   // scan and scoring datapath
   always_comb begin
      scan_in  = scan_ff;
      pc_in    = pc_ff;
      pcs_in   = pcs_ff;
      low_in   = low_ff;
      found_in = found_ff;
      rot_in   = rot_ff;
      root_in  = root_ff;
      kind_in  = kind_ff;
      first_in = first_ff;
      best_in  = best_ff;
      broot_in = broot_ff;
      bkind_in = bkind_ff;
      case (state_ff)
         S_IDLE: begin
            scan_in  = '0;
            pc_in    = '0;
            pcs_in   = '0;
            found_in = 1'b0;
         end
         S_SCAN: begin
            if (held_ff[scan_ff]) begin
               pcs_in[pc_ff] = 1'b1;
               if (!found_ff) begin
                  found_in = 1'b1;
                  low_in   = pc_ff;
               end
            end
            scan_in = scan_ff + NIDX_W'(1);
            pc_in   = (pc_ff == 4'(PC_COUNT - 1)) ? 4'd0 : pc_ff + 4'd1;
            rot_in   = pcs_in;
            root_in  = '0;
            kind_in  = '0;
            first_in = 1'b1;
         end
         S_SCORE: begin
            first_in = 1'b0;
            if (first_ff || (score > best_ff)) begin
               best_in  = score;
               broot_in = root_ff;
               bkind_in = kind_ff;
            end
            kind_in = kind_ff + 3'd1;
            if (kind_ff == 3'(KIND_COUNT - 1)) begin
               root_in = root_ff + 4'd1;
               rot_in  = {rot_ff[0], rot_ff[PC_COUNT-1:1]};
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            rsp_in.chord_found = 1'b1;
            rsp_in.chord_root  = broot_ff;
            rsp_in.chord_kind  = bkind_ff;
         end else begin
            rsp_in.chord_found = 1'b0;
            rsp_in.chord_root  = fb_root_ff;
            rsp_in.chord_kind  = fb_kind_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         fb_root_ff   <= '0;
         fb_kind_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         fb_root_ff   <= fb_root_in;
         fb_kind_ff   <= fb_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      pc_ff    <= pc_in;
      pcs_ff   <= pcs_in;
      low_ff   <= low_in;
      found_ff <= found_in;
      rot_ff   <= rot_in;
      root_ff  <= root_in;
      kind_ff  <= kind_in;
      first_ff <= first_in;
      best_ff  <= best_in;
      broot_ff <= broot_in;
      bkind_ff <= bkind_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

@@ design/hncr_checker.sv @@
`default_nettype none

`include "held_note_chord_recognizer_defines.svh"

module hncr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire hncr_pkg::rsp_type rsp_data
);
   import hncr_pkg::*;

   logic req_take;
   logic rsp_held;

   assign req_take = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // a waiting result keeps its transaction
   `HNCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one event at a time
   `HNCR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, req_stall, "second event taken while busy")

   // detected roots are real pitch classes
   `HNCR_ASSERT_IMPL(a_root_range, clock, reset, rsp_valid && rsp_data.chord_found, rsp_data.chord_root < 4'd12, "detected root out of range")

   // a fresh result only comes from a busy block
   `HNCR_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a pending event")

endmodule

bind held_note_chord_recognizer hncr_checker u_hncr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ dv/held_note_chord_recognizer_checker.sv @@
module held_note_chord_recognizer_checker #(
   parameter int unsigned NOTE_COUNT = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hncr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hncr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data,
   output int                failures
);
   timeunit 1ns;
   timeprecision 1ps;

   import hncr_pkg::*;

   typedef enum logic [2:0] {
      KIND_MAJ,
      KIND_MIN,
      KIND_DOM7,
      KIND_MAJ7,
      KIND_MIN7,
      KIND_SUS2,
      KIND_SUS4,
      KIND_ADD9
   } chord_kind_type;

   localparam int TONE_HIT   = 40;
   localparam int TONE_MISS  = -46;
   localparam int STRAY_NOTE = 13;
   localparam int BASS_BONUS = 12;

   logic [NOTE_COUNT-1:0] keys_down;
   logic [3:0]            fallback_root;
   logic [2:0]            fallback_kind;
   rsp_type               expected_chords[$];
   int                    mismatches = 0;
   int                    pending    = 0;

   assign failures = mismatches + pending;

   // Semitone offsets above the root, bit i = i semitones.
   function automatic logic [11:0] chord_shape(input logic [2:0] kind);
      case (kind)
         KIND_MAJ:  return 12'b0000_1001_0001;
         KIND_MIN:  return 12'b0000_1000_1001;
         KIND_DOM7: return 12'b0100_1001_0001;
         KIND_MAJ7: return 12'b1000_1001_0001;
         KIND_MIN7: return 12'b0100_1000_1001;
         KIND_SUS2: return 12'b0000_1000_0101;
         KIND_SUS4: return 12'b0000_1010_0001;
         default:   return 12'b0000_1001_0101;
      endcase
   endfunction

   function automatic rsp_type recognise_chord(input logic [NOTE_COUNT-1:0] keys,
                                               input logic [3:0]            fb_root,
                                               input logic [2:0]            fb_kind);
      rsp_type     chord;
      logic [11:0] classes;
      logic [11:0] shape;
      logic [11:0] tones;
      int          bass_class;
      int          best;
      int          score;
      classes    = '0;
      bass_class = -1;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         if (keys[n]) begin
            classes[n % 12] = 1'b1;
            if (bass_class < 0) bass_class = n % 12;
         end
      end
      if (bass_class < 0) begin
         chord.chord_found = 1'b0;
         chord.chord_root  = fb_root;
         chord.chord_kind  = fb_kind;
         return chord;
      end
      chord.chord_found = 1'b1;
      chord.chord_root  = 4'(bass_class);
      chord.chord_kind  = KIND_MAJ;
      best = -20000;
      for (int root = 0; root < 12; root++) begin
         for (int kind = 0; kind < 8; kind++) begin
            shape = chord_shape(3'(kind));
            tones = '0;
            for (int i = 0; i < 12; i++) begin
               if (shape[i]) tones[(i + root) % 12] = 1'b1;
            end
            score = 0;
            for (int pc = 0; pc < 12; pc++) begin
               if (tones[pc]) score += classes[pc] ? TONE_HIT : TONE_MISS;
               else if (classes[pc]) score -= STRAY_NOTE;
            end
            if (root == bass_class) score += BASS_BONUS;
            if (score > best) begin
               best             = score;
               chord.chord_root = 4'(root);
               chord.chord_kind = 3'(kind);
            end
         end
      end
      return chord;
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      req_type event_in;
      if (reset) begin
         keys_down     = '0;
         fallback_root = '0;
         fallback_kind = '0;
         expected_chords.delete();
         pending = 0;
      end else begin
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_FALLBACK_ROOT: fallback_root = csr_data;
               CSR_FALLBACK_KIND: fallback_kind = csr_data[2:0];
               default: ;
            endcase
         end
         // Result side first: a transaction accepted on this edge cannot answer yet.
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen = rsp_data;
            if (expected_chords.size() == 0) begin
               $display("%0t: unexpected result found=%0d root=%0d kind=%0d", $realtime,
                        seen.chord_found, seen.chord_root, seen.chord_kind);
               mismatches++;
            end else begin
               want = expected_chords.pop_front();
               pending--;
               if (seen.chord_found !== want.chord_found ||
                   seen.chord_root !== want.chord_root ||
                   seen.chord_kind !== want.chord_kind) begin
                  $display("%0t: chord mismatch, expected found=%0d root=%0d kind=%0d, %s",
                           $realtime, want.chord_found, want.chord_root, want.chord_kind,
                           $sformatf("got found=%0d root=%0d kind=%0d",
                                     seen.chord_found, seen.chord_root, seen.chord_kind));
                  mismatches++;
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            event_in = req_data;
            case (event_in.mode)
               MODE_NOTE_ON:
                  if (event_in.note_number < NOTE_COUNT) keys_down[event_in.note_number] = 1'b1;
               MODE_NOTE_OFF:
                  if (event_in.note_number < NOTE_COUNT) keys_down[event_in.note_number] = 1'b0;
               MODE_ALL_OFF: keys_down = '0;
               default: ;
            endcase
            expected_chords.push_back(recognise_chord(keys_down, fallback_root, fallback_kind));
            pending++;
         end
      end
   end

endmodule

@@ dv/held_note_chord_recognizer_tb.sv @@
module held_note_chord_recognizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hncr_pkg::*;

   localparam logic [1:0] MODE_SPARE    = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO  = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI  = 2'd3;
   localparam int         CYCLE_LIMIT   = 2_000_000;
   localparam int         HOLD_CYCLES   = 1500;
   localparam int         HOLD_AT       = 400;
   localparam int         END_PAUSE     = 300;
   localparam int         TONE_STEPS[8] = '{0, 2, 3, 4, 5, 7, 10, 11};

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_data  = '0;

   int           failures;
   int           sent_count = 0;
   int           rsp_count  = 0;
   int           cycles     = 0;
   bit           calm       = 1'b0;
   logic [127:0] pressed    = '0;

   held_note_chord_recognizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   held_note_chord_recognizer_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: random stalls, plus one long hold-off while the sender keeps going.
   initial begin
      int hold;
      bit hold_done;
      hold      = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) rsp_count++;
         if (hold > 0) begin
            hold--;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            hold      = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         rsp_stall <= (hold > 0) || (!calm && $urandom_range(99) < 16);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic play(input logic [1:0] mode, input int note);
      req_type item;
      item.mode        = mode;
      item.note_number = note[6:0];
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sent_count++;
      case (mode)
         MODE_NOTE_ON:  pressed[note[6:0]] = 1'b1;
         MODE_NOTE_OFF: pressed[note[6:0]] = 1'b0;
         MODE_ALL_OFF:  pressed = '0;
         default: ;
      endcase
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic settle(input int pause);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (rsp_count != sent_count) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic random_phase(input int items);
      int done;
      int pick;
      int root;
      int note;
      int k;
      done = 0;
      while (done < items) begin
         pick = $urandom_range(99);
         if ($countones(pressed) >= 8) pick = $urandom_range(45, 84);
         if (pick < 45) begin
            // chord-like burst around a random root
            root = $urandom_range(11) + 12 * $urandom_range(9);
            repeat ($urandom_range(2, 4)) begin
               note = root + TONE_STEPS[$urandom_range(7)] + 12 * $urandom_range(1);
               while (note > 127) note -= 12;
               play(MODE_NOTE_ON, note);
               done++;
            end
         end else if (pick < 75) begin
            note = $urandom_range(127);
            if (pressed != '0) begin
               k = $urandom_range($countones(pressed) - 1);
               for (int n = 0; n < 128; n++) begin
                  if (pressed[n]) begin
                     if (k == 0) note = n;
                     k--;
                  end
               end
            end
            play(MODE_NOTE_OFF, note);
            done++;
         end else if (pick < 85) begin
            play(MODE_ALL_OFF, $urandom_range(127));
            done++;
         end else if (pick < 93) begin
            play(MODE_NOTE_ON, $urandom_range(127));
            done++;
         end else if (pick < 97) begin
            play(MODE_SPARE, $urandom_range(127));
            done++;
         end else begin
            play(MODE_NOTE_OFF, $urandom_range(127));
            done++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty map under every mode, single extreme notes, repeats, common chords
      play(MODE_NOTE_OFF, 0);
      play(MODE_ALL_OFF, 0);
      play(MODE_SPARE, 127);
      play(MODE_NOTE_ON, 127);
      play(MODE_NOTE_ON, 127);
      play(MODE_NOTE_OFF, 127);
      play(MODE_NOTE_ON, 0);
      play(MODE_NOTE_ON, 60);
      play(MODE_NOTE_ON, 64);
      play(MODE_NOTE_ON, 67);
      play(MODE_SPARE, 5);
      play(MODE_NOTE_OFF, 0);
      play(MODE_NOTE_ON, 70);
      play(MODE_NOTE_OFF, 70);
      play(MODE_NOTE_ON, 71);
      play(MODE_NOTE_OFF, 64);
      play(MODE_NOTE_ON, 63);
      play(MODE_NOTE_ON, 62);
      play(MODE_ALL_OFF, 127);
      play(MODE_NOTE_ON, 57);
      play(MODE_NOTE_ON, 60);
      play(MODE_NOTE_ON, 64);
      play(MODE_NOTE_OFF, 100);
      play(MODE_ALL_OFF, 42);
      play(MODE_NOTE_OFF, 85);
      settle(8);

      write_csr(CSR_FALLBACK_ROOT, 4'd11);
      write_csr(CSR_FALLBACK_KIND, 4'd7);
      settle(0);
      random_phase(300);
      settle(8);

      // fallback values beyond their ranges, writes to unmapped indexes
      write_csr(CSR_FALLBACK_ROOT, 4'd15);
      write_csr(CSR_FALLBACK_KIND, 4'd15);
      write_csr(CSR_SPARE_LO, 4'($urandom_range(15)));
      write_csr(CSR_SPARE_HI, 4'($urandom_range(15)));
      settle(0);
      random_phase(300);
      settle(8);

      calm = 1'b1;
      write_csr(CSR_FALLBACK_ROOT, 4'd0);
      write_csr(CSR_FALLBACK_KIND, 4'd0);
      settle(0);
      random_phase(300);
      settle(8);
      calm = 1'b0;

      write_csr(CSR_FALLBACK_ROOT, 4'($urandom_range(15)));
      write_csr(CSR_FALLBACK_KIND, 4'($urandom_range(15)));
      settle(0);
      random_phase(300);
      settle(8);

      write_csr(CSR_FALLBACK_ROOT, 4'd12);
      write_csr(CSR_FALLBACK_KIND, 4'd8);
      settle(0);
      random_phase(300);
      settle(END_PAUSE);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
